// ===== hw/rtl/vdi_pkg.sv =====
// Shared constants and types for the vertex dedup indexer.
// No dependencies.
package vdi_pkg;

  localparam int MAX_VERTICES = 4096;
  localparam int HASH_BUCKETS = 4096;
  localparam int WORDS        = 9;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = IDX_W + 1;
  localparam int BKT_W        = $clog2(HASH_BUCKETS);
  localparam int STEP_W       = $clog2(WORDS);
  localparam int OUT_IDX_W    = 12;

  localparam logic [31:0] HASH_INIT = 32'h811C9DC5;
  localparam logic [31:0] HASH_MUL  = 32'h9E3779B1;

  localparam logic CMD_VERTEX = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  typedef logic [WORDS-1:0][31:0] vtx_t;

  typedef struct packed {
    logic              cmd;
    logic [BKT_W-1:0]  bucket;
    vtx_t              words;
  } req_t;

  typedef struct packed {
    vtx_t              words;
    logic [BKT_W-1:0]  bucket;
    logic [CNT_W-1:0]  link;
  } entry_t;

endpackage

// ===== hw/rtl/vertex_dedup_indexer.sv =====
// Vertex dedup indexer top level: front hash, request queue, back lookup.
// Depends on vdi_pkg, vdi_front, vdi_queue, vdi_back.
//
//   channel   handshake              payload
//   input     start / busy           in_cmd, in_pos_x .. in_normal_z
//   result    out_valid (strobe)     out_vertex_index, out_is_new, out_overflow,
//                                    out_pos_x .. out_normal_z
//
// A vertex holds busy after acceptance through nine hash multiply steps and one
// hand-off to the queue; a clear holds it only for the hand-off. A full queue
// extends it. The back end reads the bucket head, then compares one chain node
// at a time through one vertex memory read port. The 2-entry queue overlaps
// hashing with lookup. Reset empties the table at once; no clearing pass.
// Results are strobed for one cycle and cannot be stalled.
module vertex_dedup_indexer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_cmd,
  input  logic [31:0] in_pos_x,
  input  logic [31:0] in_pos_y,
  input  logic [31:0] in_pos_z,
  input  logic [31:0] in_color_r,
  input  logic [31:0] in_color_g,
  input  logic [31:0] in_color_b,
  input  logic [31:0] in_normal_x,
  input  logic [31:0] in_normal_y,
  input  logic [31:0] in_normal_z,
  output logic        out_valid,
  output logic [11:0] out_vertex_index,
  output logic        out_is_new,
  output logic        out_overflow,
  output logic [31:0] out_pos_x,
  output logic [31:0] out_pos_y,
  output logic [31:0] out_pos_z,
  output logic [31:0] out_color_r,
  output logic [31:0] out_color_g,
  output logic [31:0] out_color_b,
  output logic [31:0] out_normal_x,
  output logic [31:0] out_normal_y,
  output logic [31:0] out_normal_z
);
  import vdi_pkg::*;

  vtx_t in_words, out_words;
  req_t q_din, q_dout;
  logic q_push, q_pop, q_full, q_empty;

  always_comb begin
    in_words[0] = in_pos_x;
    in_words[1] = in_pos_y;
    in_words[2] = in_pos_z;
    in_words[3] = in_color_r;
    in_words[4] = in_color_g;
    in_words[5] = in_color_b;
    in_words[6] = in_normal_x;
    in_words[7] = in_normal_y;
    in_words[8] = in_normal_z;
  end

  vdi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_cmd   (in_cmd),
    .in_words (in_words),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_din    (q_din)
  );

  vdi_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  vdi_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_dout           (q_dout),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_vertex_index (out_vertex_index),
    .out_is_new       (out_is_new),
    .out_overflow     (out_overflow),
    .out_words        (out_words)
  );

  assign out_pos_x    = out_words[0];
  assign out_pos_y    = out_words[1];
  assign out_pos_z    = out_words[2];
  assign out_color_r  = out_words[3];
  assign out_color_g  = out_words[4];
  assign out_color_b  = out_words[5];
  assign out_normal_x = out_words[6];
  assign out_normal_y = out_words[7];
  assign out_normal_z = out_words[8];

endmodule

// ===== hw/rtl/vdi_front.sv =====
// Front end: accepts vertex and clear requests and hashes a vertex's nine words to a bucket.
// Depends on vdi_pkg.
module vdi_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  logic           in_cmd,
  input  vdi_pkg::vtx_t  in_words,
  input  logic           q_full,
  output logic           q_push,
  output vdi_pkg::req_t  q_din
);
  import vdi_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              cmd_r;
  vtx_t              words_r;
  logic [31:0]       m_r;
  logic [31:0]       h_cur, h_fin;
  logic              accept;

  assign busy   = busy_r;
  assign accept = start && !busy_r;
  assign h_cur  = (step_r == '0) ? HASH_INIT : (m_r ^ (m_r >> 15));
  assign h_fin  = m_r ^ (m_r >> 15);
  assign q_push = busy_r && done_r && !q_full;

  always_comb begin
    q_din.cmd    = cmd_r;
    q_din.bucket = h_fin[BKT_W-1:0];
    q_din.words  = words_r;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    step_nxt = step_r;
    if (accept) begin
      busy_nxt = 1'b1;
      done_nxt = (in_cmd == CMD_CLEAR);
      step_nxt = '0;
    end else if (busy_r && !done_r) begin
      if (step_r == STEP_W'(WORDS - 1)) begin
        done_nxt = 1'b1;
      end
      step_nxt = step_r + 1'b1;
    end else if (q_push) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_cmd;
      words_r <= in_words;
    end else if (busy_r && !done_r) begin
      m_r <= 32'((h_cur ^ words_r[step_r]) * HASH_MUL);
    end
  end

endmodule

// ===== hw/rtl/vdi_queue.sv =====
// Two-entry request queue between front and back ends.
// Depends on vdi_pkg.
module vdi_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  vdi_pkg::req_t  din,
  input  logic           pop,
  output vdi_pkg::req_t  dout,
  output logic           full,
  output logic           empty
);
  import vdi_pkg::*;

  req_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== hw/rtl/vdi_back.sv =====
// Back end: bucket lookup, chain walk, insert, clear and result register.
// Depends on vdi_pkg.
module vdi_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_empty,
  input  vdi_pkg::req_t                   q_dout,
  output logic                            q_pop,
  output logic                            out_valid,
  output logic [vdi_pkg::OUT_IDX_W-1:0]   out_vertex_index,
  output logic                            out_is_new,
  output logic                            out_overflow,
  output vdi_pkg::vtx_t                   out_words
);
  import vdi_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_HEAD = 2'd1;
  localparam logic [1:0] ST_CMP  = 2'd2;

  entry_t           vmem [MAX_VERTICES];
  logic [IDX_W-1:0] hmem [HASH_BUCKETS];

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             first_r, first_nxt;
  logic [IDX_W-1:0] head_rd_r;
  entry_t           vrd_r;

  logic             head_re, v_re, v_we, h_we;
  logic [IDX_W-1:0] v_ra;
  entry_t           v_wd;
  logic             ins, bvalid, hit, res;
  logic [CNT_W-1:0] nidx;

  logic                 ov_r;
  logic [OUT_IDX_W-1:0] oi_r;
  logic                 on_r, oo_r;
  vtx_t                 ow_r;
  logic [CNT_W-1:0]     res_idx;
  logic                 res_new, res_ovf;

  assign nidx = vrd_r.link - 1'b1;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    first_nxt = first_r;
    head_re   = 1'b0;
    v_re      = 1'b0;
    v_ra      = head_rd_r;
    ins       = 1'b0;
    bvalid    = 1'b0;
    hit       = 1'b0;
    q_pop     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          if (q_dout.cmd == CMD_CLEAR) begin
            q_pop     = 1'b1;
            count_nxt = '0;
          end else begin
            head_re   = 1'b1;
            state_nxt = ST_HEAD;
          end
        end
      end
      ST_HEAD: begin
        if ({1'b0, head_rd_r} < count_r) begin
          v_re      = 1'b1;
          v_ra      = head_rd_r;
          idx_nxt   = head_rd_r;
          first_nxt = 1'b1;
          state_nxt = ST_CMP;
        end else begin
          ins = 1'b1;
        end
      end
      ST_CMP: begin
        first_nxt = 1'b0;
        priority if (first_r && vrd_r.bucket != q_dout.bucket) begin
          ins = 1'b1;
        end else if (vrd_r.words == q_dout.words) begin
          hit = 1'b1;
        end else if (vrd_r.link == '0 || nidx >= count_r) begin
          ins    = 1'b1;
          bvalid = 1'b1;
        end else begin
          v_re    = 1'b1;
          v_ra    = nidx[IDX_W-1:0];
          idx_nxt = nidx[IDX_W-1:0];
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    res     = hit || ins;
    v_we    = ins && (count_r != CNT_W'(MAX_VERTICES));
    h_we    = v_we;
    res_new = v_we;
    res_ovf = ins && !v_we;
    res_idx = hit ? {1'b0, idx_r} : (v_we ? count_r : '0);
    v_wd.words  = q_dout.words;
    v_wd.bucket = q_dout.bucket;
    v_wd.link   = bvalid ? ({1'b0, head_rd_r} + 1'b1) : '0;
    if (v_we) count_nxt = count_r + 1'b1;
    if (res) begin
      q_pop     = 1'b1;
      state_nxt = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (v_we) vmem[count_r[IDX_W-1:0]] <= v_wd;
    if (v_re) vrd_r <= vmem[v_ra];
  end

  always_ff @(posedge clk) begin
    if (h_we)    hmem[q_dout.bucket] <= count_r[IDX_W-1:0];
    if (head_re) head_rd_r <= hmem[q_dout.bucket];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      idx_r   <= '0;
      first_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      first_r <= first_nxt;
      ov_r    <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (res) begin
      oi_r <= OUT_IDX_W'(res_idx);
      on_r <= res_new;
      oo_r <= res_ovf;
      ow_r <= q_dout.words;
    end
  end

  assign out_valid        = ov_r;
  assign out_vertex_index = oi_r;
  assign out_is_new       = on_r;
  assign out_overflow     = oo_r;
  assign out_words        = ow_r;

endmodule

// ===== dv/tb.sv =====
// Testbench for vertex_dedup_indexer: directed and random vertex/clear requests,
// checked against a behavioral hash-table model. Depends on vdi_pkg and the RTL.
module tb;
  import vdi_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_cmd = CMD_VERTEX;
  logic [31:0] in_w [WORDS];
  logic        out_valid;
  logic [11:0] out_vertex_index;
  logic        out_is_new, out_overflow;
  logic [31:0] out_w [WORDS];

  typedef struct {
    logic [11:0] index;
    logic        is_new;
    logic        overflow;
    logic [31:0] w [WORDS];
  } vresult_t;

  // model state
  logic [31:0] mdl_words [MAX_VERTICES][WORDS];
  bit          mdl_bvalid [HASH_BUCKETS];
  int unsigned mdl_bhead [HASH_BUCKETS];
  int unsigned mdl_link [MAX_VERTICES];
  int unsigned mdl_count;

  vresult_t    expected_q[$];
  logic [31:0] seen_q[$][WORDS];
  int          errors = 0;
  bit          idle_on = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  vertex_dedup_indexer dut (
    .clk, .rst_n, .start, .busy, .in_cmd,
    .in_pos_x(in_w[0]), .in_pos_y(in_w[1]), .in_pos_z(in_w[2]),
    .in_color_r(in_w[3]), .in_color_g(in_w[4]), .in_color_b(in_w[5]),
    .in_normal_x(in_w[6]), .in_normal_y(in_w[7]), .in_normal_z(in_w[8]),
    .out_valid, .out_vertex_index, .out_is_new, .out_overflow,
    .out_pos_x(out_w[0]), .out_pos_y(out_w[1]), .out_pos_z(out_w[2]),
    .out_color_r(out_w[3]), .out_color_g(out_w[4]), .out_color_b(out_w[5]),
    .out_normal_x(out_w[6]), .out_normal_y(out_w[7]), .out_normal_z(out_w[8])
  );

  initial for (int i = 0; i < WORDS; i++) in_w[i] = '0;

  function automatic int unsigned bucket_hash(logic [31:0] w [WORDS]);
    logic [31:0] h;
    h = HASH_INIT;
    for (int i = 0; i < WORDS; i++) begin
      h = (h ^ w[i]) * HASH_MUL;
      h = h ^ (h >> 15);
    end
    return h % HASH_BUCKETS;
  endfunction

  function automatic void predict_index(bit clr, logic [31:0] w [WORDS]);
    vresult_t    r;
    int unsigned b, idx;
    bit          hit;
    if (clr) begin
      for (int i = 0; i < HASH_BUCKETS; i++) mdl_bvalid[i] = 1'b0;
      mdl_count = 0;
      return;
    end
    hit = 1'b0;
    r.index = '0;
    r.is_new = 1'b0;
    r.overflow = 1'b0;
    r.w = w;
    b = bucket_hash(w);
    if (mdl_bvalid[b]) begin
      idx = mdl_bhead[b];
      for (int s = 0; s < MAX_VERTICES; s++) begin
        if (idx >= mdl_count) break;
        if (mdl_words[idx] == w) begin
          hit = 1'b1;
          r.index = idx[11:0];
          break;
        end
        if (mdl_link[idx] == 0) break;
        idx = mdl_link[idx] - 1;
      end
    end
    if (!hit) begin
      if (mdl_count >= MAX_VERTICES) begin
        r.overflow = 1'b1;
      end else begin
        mdl_words[mdl_count] = w;
        mdl_link[mdl_count] = mdl_bvalid[b] ? mdl_bhead[b] + 1 : 0;
        mdl_bhead[b] = mdl_count;
        mdl_bvalid[b] = 1'b1;
        r.index = mdl_count[11:0];
        r.is_new = 1'b1;
        mdl_count++;
      end
    end
    expected_q.insert(expected_q.size(), r);
  endfunction

  task automatic idle_burst();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // start stays high after acceptance; busy blocks a second accept until the
  // next request is on the ports
  task automatic send_request(bit clr, logic [31:0] w [WORDS]);
    idle_burst();
    start <= 1'b1;
    in_cmd <= clr ? CMD_CLEAR : CMD_VERTEX;
    for (int i = 0; i < WORDS; i++) in_w[i] <= w[i];
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_index(clr, w);
    if (!clr) seen_q.insert(seen_q.size(), w);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result index=%0d", out_vertex_index);
        errors++;
      end else begin
        vresult_t e;
        e = expected_q.pop_front();
        if (out_vertex_index !== e.index) begin
          $error("vertex_index exp %0d got %0d", e.index, out_vertex_index); errors++;
        end
        if (out_is_new !== e.is_new) begin
          $error("is_new exp %0b got %0b", e.is_new, out_is_new); errors++;
        end
        if (out_overflow !== e.overflow) begin
          $error("overflow exp %0b got %0b", e.overflow, out_overflow); errors++;
        end
        for (int i = 0; i < WORDS; i++)
          if (out_w[i] !== e.w[i]) begin
            $error("word%0d exp %h got %h", i, e.w[i], out_w[i]); errors++;
          end
      end
    end
  end

  function automatic void rand_vertex(output logic [31:0] w [WORDS]);
    for (int i = 0; i < WORDS; i++) w[i] = $urandom();
  endfunction

  function automatic void small_vertex(output logic [31:0] w [WORDS]);
    for (int i = 0; i < WORDS; i++) w[i] = $urandom_range(0, 1);
  endfunction

  task automatic clear_table();
    logic [31:0] w [WORDS];
    rand_vertex(w);
    send_request(1'b1, w);
    seen_q.delete();
  endtask

  task automatic test_directed();
    logic [31:0] w [WORDS];
    for (int i = 0; i < WORDS; i++) w[i] = 32'h0;
    send_request(1'b0, w);
    send_request(1'b0, w);
    w[0] = 32'h8000_0000;                 // -0 differs from +0
    send_request(1'b0, w);
    for (int i = 0; i < WORDS; i++) w[i] = 32'hFFFF_FFFF;
    send_request(1'b0, w);
    send_request(1'b0, w);
    for (int i = 0; i < WORDS; i++) w[i] = 32'h7FC0_0000;  // NaN
    send_request(1'b0, w);
    send_request(1'b0, w);
    clear_table();
    for (int i = 0; i < WORDS; i++) w[i] = 32'hFFFF_FFFF;
    send_request(1'b0, w);
    for (int i = 0; i < WORDS; i++) w[i] = 32'h0;
    send_request(1'b0, w);
  endtask

  // repeats of earlier vertices mixed with fresh ones and small patterns, with occasional table clears
  task automatic test_random_mix(int n);
    logic [31:0] w [WORDS];
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: if (seen_q.size() > 0) w = seen_q[$urandom_range(0, seen_q.size() - 1)];
                    else rand_vertex(w);
        4, 5: small_vertex(w);
        default: rand_vertex(w);
      endcase
      if ($urandom_range(0, 99) == 0) clear_table();
      else send_request(1'b0, w);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_mix(500);
    idle_on = 1'b0;
    test_random_mix(150);
    start <= 1'b0;
    while (expected_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0)
      $display("** vertex_dedup_indexer: PASSED **");
    else
      $display("** vertex_dedup_indexer: FAILED **");
    $finish;
  end

  initial begin
    #20000000;
    $display("** vertex_dedup_indexer: FAILED **");
    $finish;
  end

endmodule
